// ===== rtl/pqmf_pkg.sv =====
// pqmf_pkg: shared types and constants of the max-first priority queue
// no dependencies; imported by the interfaces and all pqmf modules
`default_nettype none

package pqmf_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned ENTRY_W      = 2 * DATA_W;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // request after classification against the running occupancy
  typedef enum logic [1:0] {
    CMD_INSERT,
    CMD_REMOVE,
    CMD_EMPTY,
    CMD_FULL
  } cmd_e;

  typedef struct packed {
    cmd_e                     kind;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_REPORT,
    BK_SHIFT
  } back_state_e;

endpackage

`default_nettype wire

// ===== rtl/pqmf_if.sv =====
// pqmf_req_if / pqmf_res_if: valid-ready channels of the priority queue
// depends on pqmf_pkg
`default_nettype none

interface pqmf_req_if import pqmf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic signed [DATA_W-1:0] item_value;
  logic signed [DATA_W-1:0] item_priority;

  modport source (output valid, output opcode, output item_value, output item_priority,
                  input ready);
  modport sink   (input valid, input opcode, input item_value, input item_priority,
                  output ready);
endinterface

interface pqmf_res_if import pqmf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] removed_value;

  modport source (output valid, output status, output removed_value, input ready);
  modport sink   (input valid, input status, input removed_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/priority_queue_max_first.sv =====
// priority_queue_max_first: top level of the bounded max-first priority queue
// depends on pqmf_pkg, pqmf_if, pqmf_front, pqmf_cmd_fifo, pqmf_back
`default_nettype none

// Bounded priority queue of CAPACITY entries. Each request on req_i is an
// insert (opcode 0, value and signed priority) or a remove (opcode 1), and
// every request yields exactly one result on res_o, in request order. An
// insert is written straight into the entry RAM by the idle back end; a
// remove scans every stored entry for the greatest priority, reports it,
// then moves each entry younger than the removed one a place toward the
// head to close the gap. Both walks share the entry RAM's one read port, and
// the next request waits until the gap is closed. The front end counts
// occupancy on its own and flags full inserts and empty removes at once, and
// a two-entry request queue plus the result register let both sides stall
// independently. Equal priorities are served oldest first. No clearing pass
// after reset is needed.
module priority_queue_max_first import pqmf_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pqmf_req_if.sink   req_i,
  pqmf_res_if.source res_o
);

  // classified requests from front to queue
  logic push_valid, push_ready;
  cmd_t push_cmd;

  // classified requests from queue to back
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  // front: accept and classify against the running occupancy
  pqmf_front #(
    .CAPACITY (CAPACITY)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  // short queue decoupling the two halves
  pqmf_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // back: store, scan, compact and report
  pqmf_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

// ===== rtl/pqmf_ram.sv =====
// pqmf_ram: generic one-write one-read RAM with registered read data
// depends on pqmf_pkg for default sizes
`default_nettype none

module pqmf_ram import pqmf_pkg::*; #(
  parameter int unsigned WIDTH = ENTRY_W,
  parameter int unsigned DEPTH = CAPACITY_DEF,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pqmf_front.sv =====
// pqmf_front: accepts requests and classifies them against its own occupancy count
// depends on pqmf_pkg and pqmf_req_if
`default_nettype none

module pqmf_front import pqmf_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pqmf_req_if.sink   req_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output cmd_t       push_cmd_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] occ_q, occ_d;
  logic             is_full, is_empty, take;

  assign is_full      = (occ_q == CNT_W'(CAPACITY));
  assign is_empty     = (occ_q == '0);
  assign take         = req_i.valid && push_ready_i;
  assign req_i.ready  = push_ready_i;
  assign push_valid_o = req_i.valid;

  always_comb begin
    push_cmd_o.value = req_i.item_value;
    push_cmd_o.prio  = req_i.item_priority;
    occ_d            = occ_q;
    if (req_i.opcode == OP_INSERT) begin
      push_cmd_o.kind = is_full ? CMD_FULL : CMD_INSERT;
      if (take && !is_full) begin
        occ_d = occ_q + CNT_W'(1);
      end
    end else begin
      push_cmd_o.kind = is_empty ? CMD_EMPTY : CMD_REMOVE;
      if (take && !is_empty) begin
        occ_d = occ_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pqmf_cmd_fifo.sv =====
// pqmf_cmd_fifo: two-entry queue of classified requests between front and back
// depends on pqmf_pkg
`default_nettype none

module pqmf_cmd_fifo import pqmf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_cmd_o    = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pqmf_back.sv =====
// pqmf_back: executes classified requests on the entry RAM and holds the result register
// depends on pqmf_pkg, pqmf_res_if and pqmf_ram
`default_nettype none

module pqmf_back import pqmf_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  cmd_t       pop_cmd_i,
  pqmf_res_if.source res_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  back_state_e              state_q, state_d;
  logic [CNT_W-1:0]         occ_q, occ_d;
  logic [CNT_W-1:0]         rd_q, rd_d;
  logic                     dv_q, dv_d;
  logic [IDX_W-1:0]         di_q, di_d;
  logic [IDX_W-1:0]         best_idx_q, best_idx_d;
  logic signed [DATA_W-1:0] best_prio_q, best_prio_d;
  logic signed [DATA_W-1:0] best_val_q, best_val_d;
  logic                     res_valid_q, res_valid_d;
  status_e                  res_status_q, res_status_d;
  logic signed [DATA_W-1:0] res_value_q, res_value_d;

  logic                     ram_we, ram_re;
  logic [IDX_W-1:0]         ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]       ram_wdata, ram_rdata;

  logic                     out_free, issue, data_last, better, take;
  logic [CNT_W-1:0]         occ_m1;
  logic [IDX_W-1:0]         last_idx;
  logic signed [DATA_W-1:0] rd_val, rd_prio;

  pqmf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free  = !res_valid_q || res_o.ready;
  assign occ_m1    = occ_q - CNT_W'(1);
  assign last_idx  = occ_m1[IDX_W-1:0];
  assign issue     = ((state_q == BK_SCAN) || (state_q == BK_SHIFT)) && (rd_q < occ_q);
  assign data_last = dv_q && (di_q == last_idx);
  assign rd_val    = $signed(ram_rdata[ENTRY_W-1:DATA_W]);
  assign rd_prio   = $signed(ram_rdata[DATA_W-1:0]);
  // strictly greater keeps the oldest among equal priorities
  assign better    = (di_q == '0) || (rd_prio > best_prio_q);

  assign pop_ready_o = (state_q == BK_IDLE) && ((pop_cmd_i.kind == CMD_REMOVE) || out_free);
  assign take        = pop_valid_i && pop_ready_o;

  assign res_o.valid         = res_valid_q;
  assign res_o.status        = res_status_q;
  assign res_o.removed_value = res_value_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (take && (pop_cmd_i.kind == CMD_REMOVE)) begin
          state_d = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (data_last) begin
          state_d = BK_REPORT;
        end
      end
      BK_REPORT: begin
        if (out_free) begin
          state_d = (best_idx_q == last_idx) ? BK_IDLE : BK_SHIFT;
        end
      end
      BK_SHIFT: begin
        if (data_last) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    occ_d        = occ_q;
    rd_d         = rd_q;
    dv_d         = issue;
    di_d         = issue ? rd_q[IDX_W-1:0] : di_q;
    best_idx_d   = best_idx_q;
    best_prio_d  = best_prio_q;
    best_val_d   = best_val_q;
    res_valid_d  = res_valid_q && !res_o.ready;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    ram_we       = 1'b0;
    ram_waddr    = occ_q[IDX_W-1:0];
    ram_wdata    = {pop_cmd_i.value, pop_cmd_i.prio};
    ram_re       = issue;
    ram_raddr    = rd_q[IDX_W-1:0];
    if (issue) begin
      rd_d = rd_q + CNT_W'(1);
    end
    case (state_q)
      BK_IDLE: begin
        if (take) begin
          case (pop_cmd_i.kind)
            CMD_INSERT: begin
              ram_we       = 1'b1;
              occ_d        = occ_q + CNT_W'(1);
              res_valid_d  = 1'b1;
              res_status_d = ST_INSERTED;
              res_value_d  = '0;
            end
            CMD_REMOVE: begin
              rd_d = '0;
            end
            CMD_EMPTY: begin
              res_valid_d  = 1'b1;
              res_status_d = ST_EMPTY;
              res_value_d  = '0;
            end
            default: begin
              res_valid_d  = 1'b1;
              res_status_d = ST_FULL;
              res_value_d  = '0;
            end
          endcase
        end
      end
      BK_SCAN: begin
        if (dv_q && better) begin
          best_idx_d  = di_q;
          best_prio_d = rd_prio;
          best_val_d  = rd_val;
        end
      end
      BK_REPORT: begin
        if (out_free) begin
          res_valid_d  = 1'b1;
          res_status_d = ST_REMOVED;
          res_value_d  = best_val_q;
          rd_d         = CNT_W'(best_idx_q) + CNT_W'(1);
          if (best_idx_q == last_idx) begin
            occ_d = occ_m1;
          end
        end
      end
      BK_SHIFT: begin
        // move each younger entry one place toward the head
        if (dv_q) begin
          ram_we    = 1'b1;
          ram_waddr = di_q - IDX_W'(1);
          ram_wdata = ram_rdata;
        end
        if (data_last) begin
          occ_d = occ_m1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      occ_q       <= '0;
      rd_q        <= '0;
      dv_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      rd_q        <= rd_d;
      dv_q        <= dv_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    di_q         <= di_d;
    best_idx_q   <= best_idx_d;
    best_prio_q  <= best_prio_d;
    best_val_q   <= best_val_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
  end

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_read_data_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q |-> ((state_q == BK_SCAN) || (state_q == BK_SHIFT)))
    else $error("read data returned outside scan or shift");

  a_shift_not_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == BK_SHIFT) && dv_q) |-> (di_q != '0))
    else $error("shift would write below the head");

  a_report_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_REPORT) |-> (occ_q != '0))
    else $error("removal reported on empty store");
`endif

endmodule

`default_nettype wire
